@@ hdl/ngpt_pkg.sv @@
// ----------------------------------------------------------------------------
// ngpt_pkg: shared types and constants of the noise-gated peak tracker
// Holds the tracker state record, its reset value and the field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ngpt_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned NoiseW    = 15;
  localparam int unsigned CountW    = 16;
  localparam int unsigned WideCntW  = 32;

  // Audio rate the since-voiced counter starts from: fifteen seconds of samples.
  localparam int unsigned SampleRate    = 48000;
  localparam logic [WideCntW-1:0] VoicedResetVal = WideCntW'(15 * SampleRate);

  localparam logic [CountW-1:0]   CountMax   = '1;
  localparam logic [WideCntW-1:0] WideCntMax = '1;

  typedef struct packed {
    logic [SampleW-1:0]  running_peak;   // two's complement
    logic [SampleW-1:0]  last_peak;      // two's complement
    logic [SampleW-1:0]  max_abs;        // magnitude, up to 32768
    logic [SampleW-1:0]  loudest_peak;   // magnitude, up to 32768
    logic [CountW-1:0]   peak_count;
    logic [CountW-1:0]   loudest_index;
    logic [WideCntW-1:0] since_voiced;
    logic [WideCntW-1:0] sample_count;
  } ngpt_state_t;

  localparam ngpt_state_t StateReset = '{
    running_peak:   '0,
    last_peak:      '0,
    max_abs:        '0,
    loudest_peak:   '0,
    peak_count:     '0,
    loudest_index:  '0,
    since_voiced:   VoicedResetVal,
    sample_count:   '0
  };

endpackage : ngpt_pkg

`default_nettype wire

@@ hdl/ngpt_update.sv @@
// ----------------------------------------------------------------------------
// ngpt_update: per-sample state update
// Combinational next state of the tracker for one sample and noise level.
// ----------------------------------------------------------------------------
`default_nettype none

module ngpt_update (
  input  ngpt_pkg::ngpt_state_t                 state_i,
  input  logic signed [ngpt_pkg::SampleW-1:0]   sample_i,
  input  logic        [ngpt_pkg::NoiseW-1:0]    noise_level_i,
  output ngpt_pkg::ngpt_state_t                 state_o,
  output logic                                  peak_event_o
);
  import ngpt_pkg::*;

  logic signed [SampleW-1:0] x;
  logic signed [SampleW-1:0] rp;
  logic signed [SampleW-1:0] rp_new;
  logic        [SampleW-1:0] ax;
  logic        [SampleW-1:0] ap;
  logic        [17:0]        nl_x5;
  logic signed [17:0]        nl_ext;
  logic signed [17:0]        border;
  logic signed [17:0]        a_diff;
  logic signed [17:0]        b_diff;
  logic                      voiced;
  logic                      same_side;
  logic                      capture;
  logic                      done;

  assign x  = sample_i;
  assign rp = $signed(state_i.running_peak);
  assign ax = x[SampleW-1] ? (~sample_i + 1'b1) : sample_i;

  assign nl_x5  = {1'b0, noise_level_i, 2'b00} + {3'b000, noise_level_i};
  assign nl_ext = $signed({3'b000, noise_level_i});

  assign voiced    = (noise_level_i != '0) && (ax > {1'b0, noise_level_i});
  // Extend the running peak only with a sample at least as far out on its side.
  assign same_side = (rp == '0) || (!rp[SampleW-1] && (x >= rp))
                                || ( rp[SampleW-1] && (x <= rp));
  assign capture   = voiced && ({2'b00, ax} > nl_x5) && same_side;
  assign rp_new    = capture ? x : rp;

  // Peak ends when the sample reaches or crosses the border on the peak's side.
  assign border = rp_new[SampleW-1] ? -nl_ext : nl_ext;
  assign a_diff = border - {{2{x[SampleW-1]}}, x};
  assign b_diff = border - {{2{rp_new[SampleW-1]}}, rp_new};
  assign done   = (rp_new != '0) &&
                  ((a_diff == '0) || (b_diff == '0) || (a_diff[17] != b_diff[17]));
  assign ap     = rp_new[SampleW-1] ? (~rp_new + 1'b1) : rp_new;

  always_comb begin
    state_o              = state_i;
    state_o.running_peak = rp_new;
    if (ax > state_i.max_abs) begin
      state_o.max_abs = ax;
    end
    if (done) begin
      state_o.running_peak = '0;
      state_o.last_peak    = rp_new;
      if (state_i.peak_count != CountMax) begin
        state_o.peak_count = state_i.peak_count + 1'b1;
      end
      if (ap > state_i.loudest_peak) begin
        state_o.loudest_peak  = ap;
        state_o.loudest_index = state_i.peak_count;
      end
    end
    if (voiced) begin
      state_o.since_voiced = WideCntW'(1);
    end else if (state_i.since_voiced != WideCntMax) begin
      state_o.since_voiced = state_i.since_voiced + 1'b1;
    end
    state_o.sample_count = state_i.sample_count + 1'b1;
    peak_event_o         = done;
  end

endmodule : ngpt_update

`default_nettype wire

@@ hdl/noise_gated_peak_tracker.sv @@
// ----------------------------------------------------------------------------
// noise_gated_peak_tracker: noise-gated audio peak tracker
// Tracks loudest sample, voiced gap and completed peaks of a Q0.15 stream.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_stall_i is low; the state update
// is a single compare and add stage between the input register and the
// result register.
// Reset: asynchronous, active low; clears all counters and peaks, sets
// since_voiced to fifteen seconds of samples and noise_level to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module noise_gated_peak_tracker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write: noise level
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [ngpt_pkg::NoiseW-1:0]     cfg_data_i,
  // sample items
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [ngpt_pkg::SampleW-1:0]    sample_i,
  // result items
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   peak_event_o,
  output logic signed [ngpt_pkg::SampleW-1:0]    peak_value_o,
  output logic        [ngpt_pkg::CountW-1:0]     peak_count_o,
  output logic        [ngpt_pkg::SampleW-1:0]    max_abs_sample_o,
  output logic        [ngpt_pkg::SampleW-1:0]    loudest_peak_o,
  output logic        [ngpt_pkg::CountW-1:0]     loudest_index_o,
  output logic        [ngpt_pkg::WideCntW-1:0]   since_voiced_o,
  output logic        [ngpt_pkg::WideCntW-1:0]   sample_count_o
);
  import ngpt_pkg::*;

  // Configuration register
  logic [NoiseW-1:0]  noise_level_q;

  // Input register
  logic               s1_valid_q, s1_valid_d;
  logic [SampleW-1:0] s1_sample_q;

  // Tracker state, updated once per committed item
  ngpt_state_t        st_q, st_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic               out_event_q, out_event_d;
  ngpt_state_t        out_st_q;

  logic               in_accept;
  logic               out_free;
  logic               commit;

  // The result register frees up when empty or when its item leaves now.
  assign out_free  = !out_valid_q || !out_stall_i;
  // Move the held sample through the update into the result register.
  assign commit    = s1_valid_q && out_free;
  // Stall only while a sample waits on a blocked result register.
  assign in_stall_o = s1_valid_q && !commit;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Writes must land only while idle; the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_level_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      noise_level_q <= cfg_data_i;
    end
  end

  ngpt_update u_update (
    .state_i       (st_q),
    .sample_i      ($signed(s1_sample_q)),
    .noise_level_i (noise_level_q),
    .state_o       (st_d),
    .peak_event_o  (out_event_d)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (commit) begin
      s1_valid_d = 1'b0;
    end
  end

  // Hold a stalled result; otherwise load whatever commits this cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = commit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= StateReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= sample_i;
    end
    if (commit) begin
      out_event_q <= out_event_d;
      out_st_q    <= st_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign peak_event_o     = out_event_q;
  assign peak_value_o     = $signed(out_st_q.last_peak);
  assign peak_count_o     = out_st_q.peak_count;
  assign max_abs_sample_o = out_st_q.max_abs;
  assign loudest_peak_o   = out_st_q.loudest_peak;
  assign loudest_index_o  = out_st_q.loudest_index;
  assign since_voiced_o   = out_st_q.since_voiced;
  assign sample_count_o   = out_st_q.sample_count;

`ifndef SYNTH
  // An empty input register never stalls the sender.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // An accepted sample is held in the input register next cycle.
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted sample lost");

  // The sample count advances by exactly one per committed item.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (st_q.sample_count == $past(st_q.sample_count) + 1'b1))
    else $error("sample count out of step with commits");

  // A committed item always shows up as a valid result.
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed item not presented");

  // A reported peak implies at least one counted peak.
  a_event_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && peak_event_o) |-> (peak_count_o != '0))
    else $error("peak event with zero peak count");
`endif

endmodule : noise_gated_peak_tracker

`default_nettype wire
